@@ rtl/atti_pkg.sv @@
// ----------------------------------------------------------------------------
// atti_pkg
// Shared sizes, codes and controller/datapath interface types for the
// ADC-to-temperature interpolator.
// ----------------------------------------------------------------------------
package atti_pkg;

    // Table and sample sizes
    localparam int TABLE_DEPTH = 128;
    localparam int SAMPLE_BITS = 12;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);   // table address
    localparam int N_W    = IDX_W + 1;             // holds 0..TABLE_DEPTH
    localparam int KEY_W  = SAMPLE_BITS;

    // Fixed field widths
    localparam int TEMP_W = 16;
    localparam int CFG_W  = 8;
    localparam int CHAN_W = 8;
    localparam int EIDX_W = 7;

    // Interpolation arithmetic
    localparam int DV_W      = TEMP_W + 1;          // value difference
    localparam int DK_W      = KEY_W + 1;           // key difference
    localparam int PROD_W    = DV_W + DK_W;
    localparam int MAG_W     = TEMP_W + KEY_W;      // |product| < 2**MAG_W
    localparam int DIV_STEPS = (MAG_W + 1) / 2;     // two quotient bits a step
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int R_W       = MAG_W + 2;

    localparam logic signed [R_W-1:0] TEMP_MAX = R_W'(32767);
    localparam logic signed [R_W-1:0] TEMP_MIN = R_W'(-32768);

    // Entry count floor
    localparam logic [CFG_W-1:0] COUNT_MIN = CFG_W'(2);

    // Channels that have a table
    localparam logic [CHAN_W-1:0] CHAN_1 = CHAN_W'(1);
    localparam logic [CHAN_W-1:0] CHAN_2 = CHAN_W'(2);

    // Opcodes
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // Table read address select
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_HI,
        RD_MID,
        RD_NBR
    } rd_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CK0,
        ST_CKHI,
        ST_SCMP,
        ST_SADDR,
        ST_NBR,
        ST_NCAP,
        ST_DINIT,
        ST_DIV,
        ST_FIN
    } ctl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        rd_sel_t rd_sel;
        logic    write_entry;
        logic    capture;
        logic    emit_error;
        logic    emit_entry;
        logic    latch_mid;
        logic    search_step;
        logic    mul;
        logic    div_init;
        logic    div_step;
        logic    emit_interp;
    } atti_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic chan_ok;
        logic le_key;
        logic ge_key;
        logic key_eq;
        logic range_open;
    } atti_sts_t;

endpackage

@@ rtl/atti_ctrl.sv @@
// ----------------------------------------------------------------------------
// atti_ctrl
// Sequencer for clamp checks, binary search, neighbor fetch and division.
// ----------------------------------------------------------------------------
module atti_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     opcode,
    input  atti_pkg::atti_sts_t      sts,
    output atti_pkg::atti_cmd_t      cmd,
    output logic                     busy
);

    atti_pkg::ctl_state_t              state_reg, state_next;
    logic [atti_pkg::DCNT_W-1:0]       cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atti_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.rd_sel = atti_pkg::RD_ZERO;

        unique case (state_reg)
            atti_pkg::ST_IDLE:
            begin
                // entry 0 is read every idle cycle, ready for a new item
                if (start)
                begin
                    if (opcode == atti_pkg::OP_LOAD)
                        cmd.write_entry = 1'b1;
                    else if (!sts.chan_ok)
                        cmd.emit_error = 1'b1;
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = atti_pkg::ST_CK0;
                    end
                end
            end
            atti_pkg::ST_CK0:
            begin
                if (sts.le_key)
                begin
                    cmd.emit_entry = 1'b1;
                    state_next     = atti_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.rd_sel = atti_pkg::RD_HI;
                    state_next = atti_pkg::ST_CKHI;
                end
            end
            atti_pkg::ST_CKHI:
            begin
                if (sts.ge_key)
                begin
                    cmd.emit_entry = 1'b1;
                    state_next     = atti_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.rd_sel = atti_pkg::RD_MID;
                    state_next = atti_pkg::ST_SCMP;
                end
            end
            atti_pkg::ST_SCMP:
            begin
                cmd.latch_mid = 1'b1;
                if (sts.key_eq)
                    state_next = atti_pkg::ST_NBR;
                else
                begin
                    cmd.search_step = 1'b1;
                    state_next      = atti_pkg::ST_SADDR;
                end
            end
            atti_pkg::ST_SADDR:
            begin
                if (sts.range_open)
                begin
                    cmd.rd_sel = atti_pkg::RD_MID;
                    state_next = atti_pkg::ST_SCMP;
                end
                else
                    state_next = atti_pkg::ST_NBR;
            end
            atti_pkg::ST_NBR:
            begin
                cmd.rd_sel = atti_pkg::RD_NBR;
                state_next = atti_pkg::ST_NCAP;
            end
            atti_pkg::ST_NCAP:
            begin
                cmd.mul    = 1'b1;
                state_next = atti_pkg::ST_DINIT;
            end
            atti_pkg::ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = atti_pkg::DCNT_W'(atti_pkg::DIV_STEPS - 1);
                state_next   = atti_pkg::ST_DIV;
            end
            atti_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = atti_pkg::ST_FIN;
                else
                    cnt_next = cnt_reg - atti_pkg::DCNT_W'(1);
            end
            atti_pkg::ST_FIN:
            begin
                cmd.emit_interp = 1'b1;
                state_next      = atti_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = atti_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != atti_pkg::ST_IDLE);

endmodule

@@ rtl/atti_dp.sv @@
// ----------------------------------------------------------------------------
// atti_dp
// Calibration table memory, search bounds, multiplier, radix-4 divider and
// result registers.
// ----------------------------------------------------------------------------
module atti_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [atti_pkg::KEY_W-1:0]          sample,
    input  logic [atti_pkg::CHAN_W-1:0]         channel,
    input  logic [atti_pkg::EIDX_W-1:0]         entry_index,
    input  logic [atti_pkg::KEY_W-1:0]          entry_adc,
    input  logic signed [atti_pkg::TEMP_W-1:0]  entry_value,
    input  logic                                cfg_we,
    input  logic [atti_pkg::CFG_W-1:0]          cfg_data,
    input  atti_pkg::atti_cmd_t                 cmd,
    output atti_pkg::atti_sts_t                 sts,
    output logic                                done,
    output logic signed [atti_pkg::TEMP_W-1:0]  temperature,
    output logic                                bad_channel
);

    // Table memory
    logic [atti_pkg::KEY_W-1:0]  key_mem  [atti_pkg::TABLE_DEPTH];
    logic [atti_pkg::TEMP_W-1:0] temp_mem [atti_pkg::TABLE_DEPTH];
    logic [atti_pkg::KEY_W-1:0]  key_rd_reg;
    logic [atti_pkg::TEMP_W-1:0] temp_rd_reg;
    logic [atti_pkg::IDX_W-1:0]  rd_addr;
    logic [atti_pkg::IDX_W-1:0]  wr_addr;
    logic                        wr_ok;

    // Configuration
    logic [atti_pkg::CFG_W-1:0]  count_reg;
    logic [atti_pkg::N_W-1:0]    n_eff;

    // Search state
    logic [atti_pkg::KEY_W-1:0]  x_reg;
    logic [atti_pkg::N_W-1:0]    lo_reg;
    logic [atti_pkg::N_W-1:0]    hi_p1_reg;
    logic [atti_pkg::IDX_W-1:0]  mid_reg;
    logic [atti_pkg::KEY_W-1:0]  kmid_reg;
    logic [atti_pkg::TEMP_W-1:0] tmid_reg;
    logic [atti_pkg::N_W:0]      mid_sum;
    logic [atti_pkg::IDX_W-1:0]  mid_calc;
    logic [atti_pkg::IDX_W-1:0]  hi_addr;
    logic [atti_pkg::IDX_W-1:0]  nbr_addr;
    logic                        below;

    // Interpolation
    logic signed [atti_pkg::DV_W-1:0]   dv;
    logic signed [atti_pkg::DK_W-1:0]   dk;
    logic signed [atti_pkg::DK_W-1:0]   span;
    logic signed [atti_pkg::PROD_W-1:0] prod_reg;
    logic signed [atti_pkg::DK_W-1:0]   span_reg;
    logic [atti_pkg::PROD_W-1:0]        pabs;
    logic [atti_pkg::DK_W-1:0]          sabs;

    // Divider
    logic [atti_pkg::DIV_W-1:0]  quo_reg;
    logic [atti_pkg::KEY_W-1:0]  rem_reg;
    logic [atti_pkg::KEY_W-1:0]  dvsr_reg;
    logic                        neg_reg;
    logic                        zero_reg;
    logic [atti_pkg::KEY_W:0]    t1, t2;
    logic                        ge1, ge2;
    logic [atti_pkg::KEY_W-1:0]  rem1, rem2;

    // Result
    logic [atti_pkg::MAG_W-1:0]         qmag;
    logic signed [atti_pkg::MAG_W:0]    q_s;
    logic signed [atti_pkg::R_W-1:0]    r_val;
    logic signed [atti_pkg::TEMP_W-1:0] r_sat;
    logic                               done_reg;
    logic signed [atti_pkg::TEMP_W-1:0] temperature_reg;
    logic                               bad_reg;

    // Entry count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= atti_pkg::COUNT_MIN;
        else if (cfg_we)
            count_reg <= cfg_data;
    end

    // Count clamped to 2..TABLE_DEPTH
    always_comb
    begin
        if (count_reg < atti_pkg::COUNT_MIN)
            n_eff = atti_pkg::N_W'(atti_pkg::COUNT_MIN);
        else if (32'(count_reg) > 32'(atti_pkg::TABLE_DEPTH))
            n_eff = atti_pkg::N_W'(atti_pkg::TABLE_DEPTH);
        else
            n_eff = atti_pkg::N_W'(count_reg);
    end

    // Address generation
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_p1_reg} - (atti_pkg::N_W + 1)'(1);
    assign mid_calc = mid_sum[atti_pkg::IDX_W:1];
    assign hi_addr  = atti_pkg::IDX_W'(hi_p1_reg - atti_pkg::N_W'(1));
    assign below    = (x_reg < kmid_reg);
    assign nbr_addr = below ? (mid_reg - atti_pkg::IDX_W'(1))
                            : (mid_reg + atti_pkg::IDX_W'(1));
    assign wr_addr  = atti_pkg::IDX_W'(entry_index);
    assign wr_ok    = (32'(entry_index) < 32'(atti_pkg::TABLE_DEPTH));

    always_comb
    begin
        unique case (cmd.rd_sel)
            atti_pkg::RD_ZERO: rd_addr = '0;
            atti_pkg::RD_HI:   rd_addr = hi_addr;
            atti_pkg::RD_MID:  rd_addr = mid_calc;
            atti_pkg::RD_NBR:  rd_addr = nbr_addr;
            default:           rd_addr = '0;
        endcase
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && wr_ok)
        begin
            key_mem[wr_addr]  <= entry_adc;
            temp_mem[wr_addr] <= entry_value;
        end
        key_rd_reg  <= key_mem[rd_addr];
        temp_rd_reg <= temp_mem[rd_addr];
    end

    // Status to controller
    assign sts.chan_ok    = (channel == atti_pkg::CHAN_1) || (channel == atti_pkg::CHAN_2);
    assign sts.le_key     = (x_reg <= key_rd_reg);
    assign sts.ge_key     = (x_reg >= key_rd_reg);
    assign sts.key_eq     = (x_reg == key_rd_reg);
    assign sts.range_open = (lo_reg < hi_p1_reg);

    // Search bounds and midpoint entry
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg     <= sample;
            lo_reg    <= '0;
            hi_p1_reg <= n_eff;
        end
        else if (cmd.search_step)
        begin
            if (key_rd_reg > x_reg)
                hi_p1_reg <= atti_pkg::N_W'(mid_reg);
            else
                lo_reg <= atti_pkg::N_W'(mid_reg) + atti_pkg::N_W'(1);
        end
        if (cmd.rd_sel == atti_pkg::RD_MID)
            mid_reg <= mid_calc;
        if (cmd.latch_mid)
        begin
            kmid_reg <= key_rd_reg;
            tmid_reg <= temp_rd_reg;
        end
    end

    // Differences against the neighbor: r = tmid + dv * dk / span
    assign dv   = {temp_rd_reg[atti_pkg::TEMP_W-1], temp_rd_reg}
                - {tmid_reg[atti_pkg::TEMP_W-1], tmid_reg};
    assign dk   = {1'b0, kmid_reg} - {1'b0, x_reg};
    assign span = {1'b0, kmid_reg} - {1'b0, key_rd_reg};

    assign pabs = prod_reg[atti_pkg::PROD_W-1] ? -prod_reg : prod_reg;
    assign sabs = span_reg[atti_pkg::DK_W-1]   ? -span_reg : span_reg;

    // Two restoring division steps per cycle
    always_comb
    begin
        t1   = {rem_reg, quo_reg[atti_pkg::DIV_W-1]};
        ge1  = (t1 >= {1'b0, dvsr_reg});
        rem1 = ge1 ? atti_pkg::KEY_W'(t1 - {1'b0, dvsr_reg}) : t1[atti_pkg::KEY_W-1:0];
        t2   = {rem1, quo_reg[atti_pkg::DIV_W-2]};
        ge2  = (t2 >= {1'b0, dvsr_reg});
        rem2 = ge2 ? atti_pkg::KEY_W'(t2 - {1'b0, dvsr_reg}) : t2[atti_pkg::KEY_W-1:0];
    end

    // Multiply and divide
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= dv * dk;
            span_reg <= span;
        end
        if (cmd.div_init)
        begin
            quo_reg  <= atti_pkg::DIV_W'(pabs[atti_pkg::MAG_W-1:0]);
            rem_reg  <= '0;
            dvsr_reg <= sabs[atti_pkg::KEY_W-1:0];
            neg_reg  <= prod_reg[atti_pkg::PROD_W-1] ^ span_reg[atti_pkg::DK_W-1];
            zero_reg <= (sabs == '0);
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[atti_pkg::DIV_W-3:0], ge1, ge2};
            rem_reg <= rem2;
        end
    end

    // Signed quotient, add and saturate; zero span gives no correction
    assign qmag = quo_reg[atti_pkg::MAG_W-1:0];

    always_comb
    begin
        if (zero_reg)
            q_s = '0;
        else if (neg_reg)
            q_s = -$signed({1'b0, qmag});
        else
            q_s = $signed({1'b0, qmag});
        r_val = $signed({{(atti_pkg::R_W - atti_pkg::TEMP_W){tmid_reg[atti_pkg::TEMP_W-1]}},
                         tmid_reg})
              + $signed({q_s[atti_pkg::MAG_W], q_s});
        if (r_val > atti_pkg::TEMP_MAX)
            r_sat = atti_pkg::TEMP_W'(atti_pkg::TEMP_MAX);
        else if (r_val < atti_pkg::TEMP_MIN)
            r_sat = atti_pkg::TEMP_W'(atti_pkg::TEMP_MIN);
        else
            r_sat = r_val[atti_pkg::TEMP_W-1:0];
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit_error | cmd.emit_entry | cmd.emit_interp;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_error)
        begin
            temperature_reg <= '0;
            bad_reg         <= 1'b1;
        end
        else if (cmd.emit_entry)
        begin
            temperature_reg <= temp_rd_reg;
            bad_reg         <= 1'b0;
        end
        else if (cmd.emit_interp)
        begin
            temperature_reg <= r_sat;
            bad_reg         <= 1'b0;
        end
    end

    assign done        = done_reg;
    assign temperature = temperature_reg;
    assign bad_channel = bad_reg;

endmodule

@@ rtl/adc_to_temperature_interp.sv @@
// ----------------------------------------------------------------------------
// adc_to_temperature_interp
// Thermistor ADC sample to temperature (tenths of a degree) by binary search
// and linear interpolation over a loadable calibration table.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item is taken on a clock edge with start high and busy low.
//   opcode load writes table slot entry_index with (entry_adc, entry_value)
//   and gives no result; busy stays low.
//   opcode convert on channel 1 or 2 returns one result; any other channel
//   returns temperature 0 with bad_channel set, on the cycle after accept.
//   Output: done is high for one cycle with temperature and bad_channel.
//   The receiver cannot stall, so a result is only shown for that cycle.
//   A convert ends after the first-entry check when the sample clamps to
//   the first entry, after the last-entry check when it clamps to the last,
//   else after search, neighbor fetch, multiply and division; done is set
//   in the first cycle with busy low again. The cost is set by the single
//   read port of the table (one entry per search step plus compare) and the
//   14-step radix-4 divider. cfg_we/cfg_data write entry_count; the user
//   must do so only while the block is idle: the block does not enforce it.
//   Reset: entry_count is 2 and the controller is idle; table contents are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module adc_to_temperature_interp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [atti_pkg::KEY_W-1:0]          sample,
    input  logic [atti_pkg::CHAN_W-1:0]         channel,
    input  logic [atti_pkg::EIDX_W-1:0]         entry_index,
    input  logic [atti_pkg::KEY_W-1:0]          entry_adc,
    input  logic signed [atti_pkg::TEMP_W-1:0]  entry_value,
    input  logic                                cfg_we,
    input  logic [atti_pkg::CFG_W-1:0]          cfg_data,
    output logic                                done,
    output logic signed [atti_pkg::TEMP_W-1:0]  temperature,
    output logic                                bad_channel
);

    atti_pkg::atti_cmd_t cmd;
    atti_pkg::atti_sts_t sts;

    // Sequencer
    atti_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Table and arithmetic
    atti_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .channel     (channel),
        .entry_index (entry_index),
        .entry_adc   (entry_adc),
        .entry_value (entry_value),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .temperature (temperature),
        .bad_channel (bad_channel)
    );

endmodule

@@ rtl/atti_chk.sv @@
// ----------------------------------------------------------------------------
// atti_chk
// Port-level checks of the interpolator's item and result timing.
// ----------------------------------------------------------------------------
module atti_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                opcode,
    input logic [atti_pkg::CHAN_W-1:0]         channel,
    input logic                                done,
    input logic signed [atti_pkg::TEMP_W-1:0]  temperature,
    input logic                                bad_channel
);

    logic conv_acc;
    logic chan_good;

    assign conv_acc  = start && !busy && (opcode == atti_pkg::OP_CONVERT);
    assign chan_good = (channel == atti_pkg::CHAN_1) || (channel == atti_pkg::CHAN_2);

    // Bad channel answers on the next cycle with an error result
    a_bad_chan: assert property (@(posedge clk) disable iff (!rst_n)
        conv_acc && !chan_good |=> done && bad_channel && (temperature == '0))
        else $error("bad channel item did not give an error result");

    // A table load never produces a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == atti_pkg::OP_LOAD) |=> !done)
        else $error("result after a table load");

    // A valid convert occupies the block
    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        conv_acc && chan_good |=> busy && !done)
        else $error("convert item did not start work");

    // Results only come out once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

endmodule

bind adc_to_temperature_interp atti_chk u_atti_chk (.*);

@@ sim/adc_to_temperature_interp_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_to_temperature_interp_tb
// Self-checking bench for the ADC-to-temperature interpolator. A scoreboard
// keeps its own copy of the calibration table and entry count, predicts the
// temperature or channel error for every accepted convert item and checks
// each done strobe against the oldest prediction. Stimulus is a short
// directed table followed by random tables (sorted, with repeated keys, or
// unsorted) under several entry counts, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module adc_to_temperature_interp_tb;
    import atti_pkg::*;

    localparam int ITEM_TARGET = 950;
    // margin past the longest convert and the done strobe after it
    localparam int TAIL_CYCLES = 48;
    // no accept, result or register write for this long means a hang
    localparam int QUIET_LIMIT = 2000;
    localparam int KEY_MAX     = (1 << KEY_W) - 1;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     bad_channel;
    } reading_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow table, entry count and outstanding readings
    // ------------------------------------------------------------------------
    class conversion_scoreboard;
        logic [KEY_W-1:0]         cal_keys  [TABLE_DEPTH];
        logic signed [TEMP_W-1:0] cal_temps [TABLE_DEPTH];
        logic [CFG_W-1:0]         entry_count;
        reading_t                 expected_q [$];
        int                       error_count;

        function new();
            foreach (cal_keys[i])
            begin
                cal_keys[i]  = '0;
                cal_temps[i] = '0;
            end
            entry_count = COUNT_MIN;
            error_count = 0;
        endfunction

        // clamp, binary search, then interpolate toward the neighbor entry
        function logic signed [TEMP_W-1:0] lookup_temp(logic [KEY_W-1:0] smp);
            int     n, lo, hi, mid, x;
            longint dv, dk, span, term, r;
            n = int'(entry_count);
            if (n < 2) n = 2;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            lo  = 0;
            hi  = n - 1;
            mid = 0;
            x   = int'(smp);
            if (x <= int'(cal_keys[0])) return cal_temps[0];
            if (x >= int'(cal_keys[hi])) return cal_temps[hi];
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (int'(cal_keys[mid]) > x) hi = mid - 1;
                else if (int'(cal_keys[mid]) < x) lo = mid + 1;
                else break;
            end
            if (x < int'(cal_keys[mid]))
            begin
                dv   = longint'(cal_temps[mid-1]) - longint'(cal_temps[mid]);
                dk   = longint'(cal_keys[mid]) - x;
                span = longint'(cal_keys[mid]) - longint'(cal_keys[mid-1]);
                term = (span == 0) ? 0 : (dv * dk) / span;
                r    = longint'(cal_temps[mid]) + term;
            end
            else
            begin
                dv   = longint'(cal_temps[mid]) - longint'(cal_temps[mid+1]);
                dk   = x - longint'(cal_keys[mid]);
                span = longint'(cal_keys[mid+1]) - longint'(cal_keys[mid]);
                term = (span == 0) ? 0 : (dv * dk) / span;
                r    = longint'(cal_temps[mid]) - term;
            end
            // only an unsorted table could push this out of range
            if (r > TEMP_MAX) r = TEMP_MAX;
            if (r < TEMP_MIN) r = TEMP_MIN;
            return r[TEMP_W-1:0];
        endfunction

        // accepted item: loads update the table, converts queue a reading
        function void note_item(logic op, logic [KEY_W-1:0] smp, logic [CHAN_W-1:0] chan,
                                logic [EIDX_W-1:0] idx, logic [KEY_W-1:0] adc,
                                logic signed [TEMP_W-1:0] val);
            reading_t want;
            if (op == OP_LOAD)
            begin
                if (int'(idx) < TABLE_DEPTH)
                begin
                    cal_keys[idx]  = adc;
                    cal_temps[idx] = val;
                end
                return;
            end
            want.bad_channel = (chan != CHAN_1 && chan != CHAN_2);
            want.temperature = want.bad_channel ? '0 : lookup_temp(smp);
            expected_q.push_back(want);
        endfunction

        function void check_result(logic signed [TEMP_W-1:0] temp, logic bad);
            reading_t want;
            if (expected_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing outstanding: temperature %0d bad_channel %0b",
                         $time, temp, bad);
                return;
            end
            want = expected_q.pop_front();
            if (temp !== want.temperature)
            begin
                error_count++;
                $display("%0t: temperature mismatch: expected %0d, actual %0d",
                         $time, want.temperature, temp);
            end
            if (bad !== want.bad_channel)
            begin
                error_count++;
                $display("%0t: bad_channel mismatch: expected %0b, actual %0b",
                         $time, want.bad_channel, bad);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     opcode;
    logic [KEY_W-1:0]         sample;
    logic [CHAN_W-1:0]        channel;
    logic [EIDX_W-1:0]        entry_index;
    logic [KEY_W-1:0]         entry_adc;
    logic signed [TEMP_W-1:0] entry_value;
    logic                     cfg_we;
    logic [CFG_W-1:0]         cfg_data;
    logic                     done;
    logic signed [TEMP_W-1:0] temperature;
    logic                     bad_channel;

    conversion_scoreboard sb;
    int                   items_sent;
    int                   burst_left;
    logic [KEY_W-1:0]     phase_keys [TABLE_DEPTH];

    adc_to_temperature_interp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .sample      (sample),
        .channel     (channel),
        .entry_index (entry_index),
        .entry_adc   (entry_adc),
        .entry_value (entry_value),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .temperature (temperature),
        .bad_channel (bad_channel)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: results first, since a result never belongs to this edge's item
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done) sb.check_result(temperature, bad_channel);
            if (start && !busy)
                sb.note_item(opcode, sample, channel, entry_index, entry_adc, entry_value);
            if (cfg_we) sb.entry_count = cfg_data;
        end
    end

    // Watchdog on cycles with no activity at all
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || done || cfg_we || (start && !busy)) quiet = 0;
            else quiet++;
        end
        $display("adc_to_temperature_interp_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each is entered and left on a rising edge
    // ------------------------------------------------------------------------
    // present one item and hold it until busy is low at an edge
    task automatic send_item(logic op, logic [KEY_W-1:0] smp, logic [CHAN_W-1:0] chan,
                             logic [EIDX_W-1:0] idx, logic [KEY_W-1:0] adc,
                             logic signed [TEMP_W-1:0] val);
        start       <= 1'b1;
        opcode      <= op;
        sample      <= smp;
        channel     <= chan;
        entry_index <= idx;
        entry_adc   <= adc;
        entry_value <= val;
        items_sent++;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // unused load fields carry random junk
    task automatic send_convert(logic [KEY_W-1:0] smp, logic [CHAN_W-1:0] chan);
        send_item(OP_CONVERT, smp, chan, EIDX_W'($urandom), KEY_W'($urandom),
                  TEMP_W'($urandom));
    endtask

    task automatic send_load(logic [EIDX_W-1:0] idx, logic [KEY_W-1:0] adc,
                             logic signed [TEMP_W-1:0] val);
        phase_keys[idx] = adc;
        send_item(OP_LOAD, KEY_W'($urandom), CHAN_W'($urandom), idx, adc, val);
    endtask

    function automatic logic [CHAN_W-1:0] pick_bad_channel();
        logic [CHAN_W-1:0] c;
        do c = CHAN_W'($urandom); while (c == CHAN_1 || c == CHAN_2);
        return c;
    endfunction

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // bursts of random length; most are followed by a gap, some run on
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
        end
    endtask

    // stop sending, wait out every reading, then let the block settle
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_entry_count(logic [CFG_W-1:0] value);
        wait_for_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // fill slots 0..n-1 in random order; keys sorted, with repeats, or unsorted
    task automatic load_table(int n);
        int                       order [TABLE_DEPTH];
        logic [KEY_W-1:0]         keys  [TABLE_DEPTH];
        int                       mode, base, maxstep, i, j, tmp, k;
        logic signed [TEMP_W-1:0] val;
        mode    = $urandom_range(0, 99);
        base    = $urandom_range(0, 40);
        maxstep = (KEY_MAX - base) / (n - 1);
        k       = base;
        for (i = 0; i < n; i++)
        begin
            if (mode < 85)
            begin
                keys[i] = KEY_W'(k);
                if (mode < 60 || $urandom_range(0, 3) != 0) k += $urandom_range(1, maxstep);
            end
            else
                keys[i] = KEY_W'($urandom);
            order[i] = i;
        end
        for (i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                val = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            else
                val = TEMP_W'($urandom);
            send_load(EIDX_W'(order[i]), keys[order[i]], val);
            // channel errors read no table, so they may come mid-load
            if ($urandom_range(0, 9) == 0)
            begin
                pace();
                send_convert(KEY_W'($urandom), pick_bad_channel());
            end
            pace();
        end
    endtask

    // converts aimed at keys, their neighbors and the ends, plus stray loads
    task automatic exercise_table(int n, int count);
        int                pick, i;
        logic [KEY_W-1:0]  smp;
        logic [CHAN_W-1:0] chan;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            i    = $urandom_range(0, n - 1);
            if (pick < 8)
                send_load(EIDX_W'($urandom), KEY_W'($urandom), TEMP_W'($urandom));
            else
            begin
                if (pick < 40) smp = phase_keys[i];
                else if (pick < 50) smp = phase_keys[i] + 1'b1;
                else if (pick < 58) smp = phase_keys[i] - 1'b1;
                else if (pick < 64) smp = $urandom_range(0, 1) ? KEY_W'(KEY_MAX) : '0;
                else smp = KEY_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 45) chan = CHAN_1;
                else if (pick < 90) chan = CHAN_2;
                else chan = CHAN_W'($urandom);
                send_convert(smp, chan);
            end
            pace();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int phase, cfg, n;
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_CONVERT;
        sample      = '0;
        channel     = '0;
        entry_index = '0;
        entry_adc   = '0;
        entry_value = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        items_sent  = 0;
        burst_left  = 0;
        foreach (phase_keys[i]) phase_keys[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // channels without a table, before anything is loaded
        send_convert(KEY_W'(KEY_MAX), 8'd0);
        send_convert('0, 8'd255);
        send_convert(12'd2048, 8'd3);

        // four entries: full-scale values and a repeated key
        write_entry_count(8'd4);
        send_load(7'd0, 12'd0, 16'sh7FFF);
        send_load(7'd1, 12'd50, 16'sh8000);
        send_load(7'd2, 12'd50, 16'sd100);
        send_load(7'd3, 12'd4095, 16'sh8000);
        send_load(7'd127, 12'd4095, 16'sd0);   // top slot, outside the active range
        send_convert(12'd0, CHAN_1);           // clamp to first entry
        send_convert(12'd4095, CHAN_2);        // clamp to last entry
        send_convert(12'd50, CHAN_1);          // exact hit, next key equal: zero span
        send_convert(12'd25, CHAN_2);          // full-swing slope
        send_convert(12'd51, CHAN_1);
        send_convert(12'd2000, CHAN_2);
        send_convert(12'd1, CHAN_1);
        send_convert(12'd4094, CHAN_2);
        send_convert(12'd49, 8'd255);

        // random tables, count extremes first (out-of-range counts clamp)
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0:       cfg = 255;
                1:       cfg = 0;
                2:       cfg = 1;
                3:       cfg = TABLE_DEPTH;
                4:       cfg = 2;
                default:
                begin
                    tmp_pick: begin
                        int roll;
                        roll = $urandom_range(0, 9);
                        if (roll < 7) cfg = $urandom_range(3, 16);
                        else if (roll < 9) cfg = $urandom_range(17, TABLE_DEPTH - 1);
                        else cfg = $urandom_range(TABLE_DEPTH + 1, 255);
                    end
                end
            endcase
            n = (cfg < 2) ? 2 : (cfg > TABLE_DEPTH) ? TABLE_DEPTH : cfg;
            write_entry_count(CFG_W'(cfg));
            load_table(n);
            exercise_table(n, $urandom_range(40, 80));
            phase++;
        end

        wait_for_results();
        if (sb.error_count == 0 && sb.expected_q.size() == 0)
            $display("adc_to_temperature_interp_tb: PASS");
        else
            $display("adc_to_temperature_interp_tb: FAIL");
        $finish;
    end

endmodule
